// File: rtl/blf_pkg.sv
package blf_pkg;

    // field widths
    localparam int RAW_W    = 12;
    localparam int SAMPLE_W = 13;
    localparam int LEVEL_W  = 3;
    localparam int CAL_W    = 11;
    localparam int OFS_W    = 8;
    localparam int CFG_W    = 13;

    // largest corrected sample, also the fixed threshold of unused levels
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 13'd8191;

    // number of threshold slots that the level compare can use
    localparam int LEVEL_MAX = 8;
    localparam int LEVEL_CFG = 4;

    // empty counter limits
    localparam logic [2:0] EMPTY_SAT  = 3'd5;
    localparam logic [2:0] EMPTY_FLAG = 3'd4;

    // register reset values
    localparam logic signed [CAL_W-1:0] CAL_RESET    = 11'sd0;
    localparam logic [OFS_W-1:0]        CHARGE_RESET = 8'd100;
    localparam logic [OFS_W-1:0]        LENS_RESET   = 8'd95;
    localparam logic [SAMPLE_W-1:0]     THR_RESET [LEVEL_CFG] =
        '{13'd2643, 13'd2762, 13'd2799, 13'd2830};

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CAL_OFFSET      = 3'd0,
        REG_CHARGE_OFFSET   = 3'd1,
        REG_LENS_OFFSET     = 3'd2,
        REG_THRESHOLD_ONE   = 3'd3,
        REG_THRESHOLD_TWO   = 3'd4,
        REG_THRESHOLD_THREE = 3'd5,
        REG_THRESHOLD_FOUR  = 3'd6
    } blf_reg_e;

    // one raw sample request
    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
        logic             charging;
        logic             lens_moving;
    } blf_in_t;

    // one filtered result
    typedef struct packed {
        logic [SAMPLE_W-1:0] corrected_sample;
        logic [SAMPLE_W-1:0] window_average;
        logic [LEVEL_W-1:0]  reported_level;
        logic                empty_res;
    } blf_out_t;

endpackage

// File: rtl/blf_ram.sv
module blf_ram
    import blf_pkg::*;
#(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/battery_level_filter.sv
// battery_level_filter
//
// Takes raw battery converter samples on the sample channel (valid/ready) and
// returns one result request per sample on the result channel: the corrected
// sample, the mean of the last WINDOW_DEPTH corrected samples, the debounced
// battery level and a one-shot empty flag. Offsets and level thresholds are
// written through the cfg channel (index, data), which is always ready; write
// it only while no sample is in flight.
//
// From the input register, the correction, running-total update, reciprocal-multiply
// mean and threshold compare run combinationally into the result register.
// Throughput is one sample per cycle while the receiver does not stall; the
// running total and a window RAM read one slot ahead keep the window update
// to a single add and subtract.
//
// Reset clears the pipeline, loads the register defaults and empties the
// window; the first sample after reset fills the whole window. When the
// receiver stalls, the result register holds and the input register takes
// one more sample before sample_ready drops.
module battery_level_filter
    import blf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int LEVEL_COUNT  = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_ready,
    input  blf_in_t  sample,
    output logic     result_valid,
    input  logic     result_ready,
    output blf_out_t result,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  blf_reg_e cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
    localparam int TOTAL_W  = SAMPLE_W + SLOT_W;
    // exact floor division by the window depth for any TOTAL_W-bit total
    localparam int SHIFT    = TOTAL_W + SLOT_W;
    localparam int RECIP_W  = TOTAL_W + 1;
    localparam int PROD_W   = TOTAL_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(WINDOW_DEPTH) - 64'd1) / longint'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    // configuration registers
    logic signed [CAL_W-1:0] cal_reg;
    logic [OFS_W-1:0]        charge_reg;
    logic [OFS_W-1:0]        lens_reg;
    logic [SAMPLE_W-1:0]     thr_reg [LEVEL_CFG];

    // pipeline registers
    logic     s0_valid_reg;
    blf_in_t  s0_data_reg;
    logic     res_valid_reg;
    blf_out_t res_data_reg;
    blf_out_t res_data_next;

    // filter state
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       slot_next;
    logic [TOTAL_W-1:0]      total_reg;
    logic [TOTAL_W-1:0]      total_next;
    logic [WINDOW_DEPTH-1:0] filled_reg;
    logic [SAMPLE_W-1:0]     fill_reg;
    logic                    started_reg;
    logic [LEVEL_W-1:0]      prev_level_reg;
    logic [LEVEL_W-1:0]      held_level_reg;
    logic [LEVEL_W-1:0]      held_level_next;
    logic                    even_reg;
    logic [2:0]              empty_cnt_reg;
    logic [2:0]              empty_cnt_next;

    // datapath
    logic                        advance;
    logic signed [CAL_W-1:0]     cal_adj;
    logic signed [CAL_W-2:0]     cal_half;
    logic [OFS_W-1:0]            ofs_sel;
    logic signed [SAMPLE_W:0]    sum;
    logic [SAMPLE_W-1:0]         corr;
    logic [SAMPLE_W-1:0]         ram_q;
    logic [SAMPLE_W-1:0]         old_sample;
    logic [RECIP_W-1:0]          recip;
    logic [PROD_W-1:0]           prod;
    logic [SAMPLE_W-1:0]         avg;
    logic [SAMPLE_W-1:0]         thr [LEVEL_MAX];
    logic [LEVEL_W-1:0]          level;
    logic                        empty_hit;

    // handshakes
    assign advance      = s0_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !s0_valid_reg || advance;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg    <= CAL_RESET;
            charge_reg <= CHARGE_RESET;
            lens_reg   <= LENS_RESET;
            for (int i = 0; i < LEVEL_CFG; i++)
            begin
                thr_reg[i] <= THR_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAL_OFFSET:      cal_reg    <= $signed(cfg_data[CAL_W-1:0]);
                REG_CHARGE_OFFSET:   charge_reg <= cfg_data[OFS_W-1:0];
                REG_LENS_OFFSET:     lens_reg   <= cfg_data[OFS_W-1:0];
                REG_THRESHOLD_ONE:   thr_reg[0] <= cfg_data[SAMPLE_W-1:0];
                REG_THRESHOLD_TWO:   thr_reg[1] <= cfg_data[SAMPLE_W-1:0];
                REG_THRESHOLD_THREE: thr_reg[2] <= cfg_data[SAMPLE_W-1:0];
                REG_THRESHOLD_FOUR:  thr_reg[3] <= cfg_data[SAMPLE_W-1:0];
                default:             ;
            endcase
        end
    end

    // sample correction: offset, half calibration truncated toward zero, clamp
    always_comb
    begin
        cal_adj  = cal_reg + $signed({{(CAL_W-1){1'b0}}, cal_reg[CAL_W-1]});
        cal_half = (CAL_W-1)'(cal_adj >>> 1);
        if (s0_data_reg.charging)
        begin
            ofs_sel = charge_reg;
        end
        else if (s0_data_reg.lens_moving)
        begin
            ofs_sel = lens_reg;
        end
        else
        begin
            ofs_sel = '0;
        end
        sum = $signed({2'b00, s0_data_reg.raw_sample})
            + $signed({{(SAMPLE_W+1-OFS_W){1'b0}}, ofs_sel})
            + (SAMPLE_W+1)'(cal_half);
        // the sum cannot pass the upper bound, only the lower one
        if (sum < 0)
        begin
            corr = '0;
        end
        else
        begin
            corr = sum[SAMPLE_W-1:0];
        end
    end

    // window store, read one slot ahead of the write
    blf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (advance && started_reg),
        .wr_addr (slot_reg),
        .wr_data (corr),
        .rd_addr (slot_next),
        .rd_data (ram_q)
    );

    // slots not yet written still hold the first sample
    assign old_sample = filled_reg[slot_reg] ? ram_q : fill_reg;

    // running total and slot pointer
    always_comb
    begin
        slot_next = slot_reg;
        if (!started_reg)
        begin
            total_next = TOTAL_W'(corr) * TOTAL_W'(WINDOW_DEPTH);
        end
        else
        begin
            total_next = total_reg - TOTAL_W'(old_sample) + TOTAL_W'(corr);
        end
        if (advance && started_reg)
        begin
            slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    // window mean by reciprocal multiply
    assign recip = RECIP_W'(RECIP);
    assign prod  = PROD_W'(total_next) * PROD_W'(recip);
    assign avg   = started_reg ? SAMPLE_W'(prod >> SHIFT) : corr;

    // level compare, highest exceeded threshold wins
    always_comb
    begin
        for (int i = 0; i < LEVEL_MAX; i++)
        begin
            thr[i] = (i < LEVEL_CFG) ? thr_reg[i % LEVEL_CFG] : SAMPLE_MAX;
        end
        level = '0;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (avg > thr[i])
            begin
                level = LEVEL_W'(i + 1);
            end
        end
    end

    // debounce and empty counter
    always_comb
    begin
        if (level == prev_level_reg || !started_reg || even_reg)
        begin
            held_level_next = level;
        end
        else
        begin
            held_level_next = held_level_reg;
        end
        empty_cnt_next = empty_cnt_reg;
        empty_hit      = 1'b0;
        if (empty_cnt_reg != '0 || held_level_next == '0)
        begin
            if (empty_cnt_reg < EMPTY_SAT)
            begin
                empty_cnt_next = empty_cnt_reg + 1'b1;
            end
            empty_hit = (empty_cnt_next == EMPTY_FLAG);
        end
        res_data_next.corrected_sample = corr;
        res_data_next.window_average   = avg;
        res_data_next.reported_level   = held_level_next;
        res_data_next.empty_res        = empty_hit;
    end

    // pipeline control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            slot_reg       <= '0;
            total_reg      <= '0;
            filled_reg     <= '0;
            started_reg    <= 1'b0;
            prev_level_reg <= '0;
            held_level_reg <= '0;
            even_reg       <= 1'b1;
            empty_cnt_reg  <= '0;
        end
        else
        begin
            if (sample_ready)
            begin
                s0_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                slot_reg       <= slot_next;
                total_reg      <= total_next;
                started_reg    <= 1'b1;
                prev_level_reg <= level;
                held_level_reg <= held_level_next;
                even_reg       <= !even_reg;
                empty_cnt_reg  <= empty_cnt_next;
                if (started_reg)
                begin
                    filled_reg[slot_reg] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            s0_data_reg <= sample;
        end
        if (advance)
        begin
            res_data_reg <= res_data_next;
        end
        if (advance && !started_reg)
        begin
            fill_reg <= corr;
        end
    end

endmodule
